[rtl/swsp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swsp_pkg;

  // result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_ARG_END = 2'd1;
  localparam logic [1:0] KIND_DONE = 2'd2;

  // status codes
  localparam logic [3:0] ST_OK = 4'd0;
  localparam logic [3:0] ST_EMPTY = 4'd1;
  localparam logic [3:0] ST_TOO_LONG = 4'd2;
  localparam logic [3:0] ST_CONTROL = 4'd3;
  localparam logic [3:0] ST_OPEN_ESCAPE = 4'd4;
  localparam logic [3:0] ST_ARG_LONG = 4'd5;
  localparam logic [3:0] ST_MANY_ARGS = 4'd6;
  localparam logic [3:0] ST_OPEN_QUOTE = 4'd7;
  localparam logic [3:0] ST_NO_ARG = 4'd8;
  localparam logic [3:0] ST_EMPTY_FIRST = 4'd9;

  // quote modes
  localparam logic [1:0] QM_NONE = 2'd0;
  localparam logic [1:0] QM_SINGLE = 2'd1;
  localparam logic [1:0] QM_DOUBLE = 2'd2;

  // assignment word tracking
  localparam logic [1:0] ASN_FIRST = 2'd0;
  localparam logic [1:0] ASN_NAME = 2'd1;
  localparam logic [1:0] ASN_SEEN = 2'd2;
  localparam logic [1:0] ASN_NOT = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_MAX_REQUEST = 2'd0;
  localparam logic [1:0] CFG_MAX_ARGUMENT = 2'd1;
  localparam logic [1:0] CFG_MAX_ARGV = 2'd2;

  localparam int REQ_W = 15;
  localparam int ARG_W = 13;
  localparam int CNT_W = 8;
  localparam int CFG_DATA_W = 15;

  localparam logic [REQ_W-1:0] REQ_SAT = 15'h7fff;
  localparam logic [ARG_W-1:0] ARG_SAT = 13'h1fff;

  typedef struct packed {
    logic [REQ_W-1:0] max_req;
    logic [ARG_W-1:0] max_arg;
    logic [CNT_W-1:0] max_argv;
  } swsp_cfg_t;

  typedef struct packed {
    logic [1:0]       quote;
    logic             esc_pending;
    logic             in_arg;
    logic [ARG_W-1:0] arg_len;
    logic [CNT_W-1:0] arg_total;
    logic [REQ_W-1:0] req_len;
    logic             shell_flag;
    logic             ctrl_seen;
    logic [3:0]       first_err;
    logic [1:0]       assign_trk;
    logic             first_arg_empty;
  } swsp_state_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       out_byte;
    logic [3:0]       status;
    logic             needs_raw_shell;
    logic [CNT_W-1:0] arg_count;
    logic             final_result;
  } swsp_result_t;

  // all results of one command byte
  typedef struct packed {
    swsp_result_t [3:0] res;
    logic [2:0]         count;
  } swsp_bundle_t;

endpackage

`default_nettype wire

[rtl/swsp_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface swsp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;
  logic       empty_command;

  modport source (output valid, output data_byte, output last, output empty_command,
                  input ready);
  modport sink (input valid, input data_byte, input last, input empty_command,
                output ready);
endinterface

`default_nettype wire

[rtl/swsp_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface swsp_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic [3:0] status;
  logic       needs_raw_shell;
  logic [7:0] arg_count;
  logic       final_result;

  modport source (output valid, output kind, output out_byte, output status,
                  output needs_raw_shell, output arg_count, output final_result,
                  input ready);
  modport sink (input valid, input kind, input out_byte, input status,
                input needs_raw_shell, input arg_count, input final_result,
                output ready);
endinterface

`default_nettype wire

[rtl/swsp_parse.sv]
`timescale 1ns / 1ps
`default_nettype none

// One command byte against the parser state: next state and up to four results.
module swsp_parse
  import swsp_pkg::*;
(
  input  swsp_state_t  state,
  input  swsp_cfg_t    cfg,
  input  logic [7:0]   data_byte,
  input  logic         last,
  input  logic         empty_command,
  output swsp_state_t  state_next,
  output swsp_bundle_t bundle
);

  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_BTICK = 8'h60;
  localparam logic [7:0] CH_EQUAL = 8'h3d;
  localparam logic [7:0] CH_USCORE = 8'h5f;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DEL = 8'h7f;

  function automatic logic is_alpha(logic [7:0] b);
    return (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a);
  endfunction

  function automatic logic is_name_char(logic [7:0] b);
    return is_alpha(b) || (b >= 8'h30 && b <= 8'h39) || b == CH_USCORE;
  endfunction

  function automatic logic is_meta(logic [7:0] b);
    logic m;
    case (b)
      8'h3b, 8'h26, 8'h7c, 8'h3c, 8'h3e, 8'h60, 8'h24, 8'h28, 8'h29,
      8'h2a, 8'h3f, 8'h5b, 8'h5d, 8'h7b, 8'h7d, 8'h7e, 8'h23, 8'h21: m = 1'b1;
      default: m = 1'b0;
    endcase
    return m;
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return b == CH_SPACE || (b >= 8'h09 && b <= 8'h0d);
  endfunction

  function automatic swsp_result_t mk_res(logic [1:0] kind, logic [7:0] b, logic [3:0] st,
                                          swsp_state_t s);
    swsp_result_t r;
    r.kind = kind;
    r.out_byte = b;
    r.status = st;
    r.needs_raw_shell = s.shell_flag;
    r.arg_count = s.arg_total;
    r.final_result = 1'b0;
    return r;
  endfunction

  // state update for one decoded argument byte
  function automatic swsp_state_t emit_upd(swsp_state_t s, logic [7:0] b);
    swsp_state_t t;
    t = s;
    if (t.arg_len != ARG_SAT) t.arg_len = t.arg_len + ARG_W'(1);
    if (t.arg_total == '0) begin
      if (t.assign_trk == ASN_FIRST)
        t.assign_trk = (is_alpha(b) || b == CH_USCORE) ? ASN_NAME : ASN_NOT;
      else if (t.assign_trk == ASN_NAME)
        t.assign_trk = (b == CH_EQUAL) ? ASN_SEEN : (is_name_char(b) ? ASN_NAME : ASN_NOT);
    end
    t.in_arg = 1'b1;
    return t;
  endfunction

  // close the open argument; the end mark goes out when no error was raised
  function automatic swsp_state_t close_upd(swsp_state_t s, swsp_cfg_t c);
    swsp_state_t t;
    t = s;
    if (t.in_arg) begin
      if (t.arg_len > c.max_arg) begin
        t.first_err = ST_ARG_LONG;
      end else if (t.arg_total >= c.max_argv) begin
        t.first_err = ST_MANY_ARGS;
      end else begin
        if (t.arg_total == '0) begin
          if (t.assign_trk == ASN_SEEN) t.shell_flag = 1'b1;
          if (t.arg_len == '0) t.first_arg_empty = 1'b1;
        end
        t.arg_total = t.arg_total + CNT_W'(1);
        t.arg_len = '0;
        t.in_arg = 1'b0;
      end
    end
    return t;
  endfunction

  always_comb begin
    swsp_state_t  s;
    swsp_state_t  c;
    swsp_result_t r [4];
    logic [2:0]   n;
    logic [3:0]   st;
    logic [1:0]   li;
    s = state;
    c = state;
    n = 3'd0;
    st = ST_OK;
    for (int i = 0; i < 4; i++) r[i] = '0;

    if (empty_command) begin
      s = '0;
      r[0] = mk_res(KIND_DONE, 8'h00, ST_EMPTY, s);
      n = 3'd1;
    end else begin
      if (s.req_len != REQ_SAT) s.req_len = s.req_len + REQ_W'(1);
      if (data_byte < CH_SPACE || data_byte == CH_DEL) s.ctrl_seen = 1'b1;

      // byte parsing
      if (s.first_err == ST_OK) begin
        if (s.esc_pending) begin
          s.esc_pending = 1'b0;
          if (s.quote == QM_DOUBLE && !(data_byte == CH_DOLLAR || data_byte == CH_BTICK ||
                                       data_byte == CH_DQUOTE || data_byte == CH_BSLASH)) begin
            r[n[1:0]] = mk_res(KIND_BYTE, CH_BSLASH, ST_OK, s);
            n = n + 3'd1;
            s = emit_upd(s, CH_BSLASH);
          end
          r[n[1:0]] = mk_res(KIND_BYTE, data_byte, ST_OK, s);
          n = n + 3'd1;
          s = emit_upd(s, data_byte);
        end else if (s.quote == QM_SINGLE) begin
          if (data_byte == CH_SQUOTE) begin
            s.quote = QM_NONE;
          end else begin
            r[n[1:0]] = mk_res(KIND_BYTE, data_byte, ST_OK, s);
            n = n + 3'd1;
            s = emit_upd(s, data_byte);
          end
          s.in_arg = 1'b1;
        end else if (s.quote == QM_DOUBLE) begin
          if (data_byte == CH_DQUOTE) begin
            s.quote = QM_NONE;
            s.in_arg = 1'b1;
          end else if (data_byte == CH_BSLASH) begin
            if (last) s.first_err = ST_OPEN_ESCAPE;
            else s.esc_pending = 1'b1;
          end else begin
            if (data_byte == CH_DOLLAR || data_byte == CH_BTICK) s.shell_flag = 1'b1;
            r[n[1:0]] = mk_res(KIND_BYTE, data_byte, ST_OK, s);
            n = n + 3'd1;
            s = emit_upd(s, data_byte);
          end
        end else begin
          if (data_byte == CH_BSLASH) begin
            if (last) s.first_err = ST_OPEN_ESCAPE;
            else s.esc_pending = 1'b1;
          end else if (data_byte == CH_SQUOTE) begin
            s.quote = QM_SINGLE;
            s.in_arg = 1'b1;
          end else if (data_byte == CH_DQUOTE) begin
            s.quote = QM_DOUBLE;
            s.in_arg = 1'b1;
          end else if (is_blank(data_byte)) begin
            c = close_upd(s, cfg);
            if (s.in_arg && c.first_err == ST_OK) begin
              r[n[1:0]] = mk_res(KIND_ARG_END, 8'h00, ST_OK, c);
              n = n + 3'd1;
            end
            s = c;
          end else begin
            if (is_meta(data_byte)) s.shell_flag = 1'b1;
            r[n[1:0]] = mk_res(KIND_BYTE, data_byte, ST_OK, s);
            n = n + 3'd1;
            s = emit_upd(s, data_byte);
          end
        end
      end

      // end of command checks and status
      if (last) begin
        if (s.first_err == ST_OK) begin
          if (s.quote != QM_NONE) begin
            s.first_err = ST_OPEN_QUOTE;
          end else begin
            c = close_upd(s, cfg);
            if (s.in_arg && c.first_err == ST_OK) begin
              r[n[1:0]] = mk_res(KIND_ARG_END, 8'h00, ST_OK, c);
              n = n + 3'd1;
            end
            s = c;
            if (s.first_err == ST_OK) begin
              if (s.arg_total == '0) s.first_err = ST_NO_ARG;
              else if (s.first_arg_empty) s.first_err = ST_EMPTY_FIRST;
            end
          end
        end
        if (s.req_len > cfg.max_req) st = ST_TOO_LONG;
        else if (s.ctrl_seen) st = ST_CONTROL;
        else st = s.first_err;
        r[n[1:0]] = mk_res(KIND_DONE, 8'h00, st, s);
        n = n + 3'd1;
        s = '0;
      end
    end

    // tag the last result of this byte
    li = 2'(n - 3'd1);
    if (n != 3'd0) r[li].final_result = 1'b1;

    state_next = s;
    for (int i = 0; i < 4; i++) bundle.res[i] = r[i];
    bundle.count = n;
  end

endmodule

`default_nettype wire

[rtl/swsp_out_buf.sv]
`timescale 1ns / 1ps
`default_nettype none

// Result register: holds the words of one byte and hands them out one per cycle while tok_out is ready.
module swsp_out_buf
  import swsp_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                load_req,
  input  swsp_bundle_t        bundle,
  output logic                can_load,
  swsp_out_if.source          tok_out
);

  swsp_result_t res [4];
  logic [2:0]   rem;
  logic [1:0]   idx;
  logic         take;
  logic         load;

  assign take = (rem != 3'd0) && tok_out.ready;
  assign can_load = (rem == 3'd0) || (take && rem == 3'd1);
  assign load = load_req && can_load;

  // count and read pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 3'd0;
      idx <= 2'd0;
    end else if (load) begin
      rem <= bundle.count;
      idx <= 2'd0;
    end else if (take) begin
      rem <= rem - 3'd1;
      idx <= idx + 2'd1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < 4; i++) res[i] <= bundle.res[i];
    end
  end

  assign tok_out.valid = (rem != 3'd0);
  assign tok_out.kind = res[idx].kind;
  assign tok_out.out_byte = res[idx].out_byte;
  assign tok_out.status = res[idx].status;
  assign tok_out.needs_raw_shell = res[idx].needs_raw_shell;
  assign tok_out.arg_count = res[idx].arg_count;
  assign tok_out.final_result = res[idx].final_result;

  a_rem_bound: assert property (@(posedge clk) disable iff (rst) rem <= 3'd4)
    else $error("result count above four");
  a_final_tag: assert property (@(posedge clk) disable iff (rst)
    (rem != 3'd0) |-> (res[idx].final_result == (rem == 3'd1)))
    else $error("final tag not on the last word of a byte");
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (take && rem > 3'd1) |=> (rem == $past(rem) - 3'd1))
    else $error("pending words lost");

endmodule

`default_nettype wire

[rtl/shell_word_splitter_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Word fields
// cmd_in    in   data_byte[7:0], last, empty_command
// tok_out   out  kind[1:0], out_byte[7:0], status[3:0], needs_raw_shell,
//                arg_count[7:0], final_result
// cfg_*     in   cfg_we, cfg_index[1:0], cfg_wdata[14:0] (write only)
//
// A byte is taken into an input register, parsed combinationally into zero
// to four result words on its way into the result register, and those words
// go out one per cycle while tok_out is ready. Throughput is one byte per
// cycle while each byte yields at most one word; a byte with more words
// holds the input until its last word is taken. Synchronous reset clears
// parser state and loads the limits from the parameters. A stalled output
// holds its word and backs up into the input register.
module shell_word_splitter_core
  import swsp_pkg::*;
#(
  parameter int MAX_REQUEST = 16384,
  parameter int MAX_ARGUMENT = 4096,
  parameter int MAX_ARGS = 128
) (
  input  logic                  clk,
  input  logic                  rst,
  swsp_in_if.sink               cmd_in,
  swsp_out_if.source            tok_out,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic [REQ_W-1:0] REQ_RST =
    (MAX_REQUEST > 32767) ? REQ_SAT : REQ_W'(MAX_REQUEST);
  localparam logic [ARG_W-1:0] ARG_RST =
    (MAX_ARGUMENT > 8191) ? ARG_SAT : ARG_W'(MAX_ARGUMENT);
  localparam logic [CNT_W-1:0] ARGV_RST =
    (MAX_ARGS > 255) ? 8'hff : CNT_W'(MAX_ARGS);

  swsp_cfg_t    cfg;
  swsp_state_t  state;
  swsp_state_t  state_next;
  swsp_bundle_t bundle;

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_last;
  logic       in_empty;
  logic       can_load;
  logic       load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_req <= REQ_RST;
      cfg.max_arg <= ARG_RST;
      cfg.max_argv <= ARGV_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_REQUEST:  cfg.max_req <= cfg_wdata[REQ_W-1:0];
        CFG_MAX_ARGUMENT: cfg.max_arg <= cfg_wdata[ARG_W-1:0];
        CFG_MAX_ARGV:     cfg.max_argv <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  assign load = in_full && can_load;
  assign cmd_in.ready = !in_full || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (cmd_in.ready) begin
      in_full <= cmd_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_in.valid && cmd_in.ready) begin
      in_byte <= cmd_in.data_byte;
      in_last <= cmd_in.last;
      in_empty <= cmd_in.empty_command;
    end
  end

  // parser state advances as the byte moves into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (load) begin
      state <= state_next;
    end
  end

  swsp_parse u_parse (
    .state         (state),
    .cfg           (cfg),
    .data_byte     (in_byte),
    .last          (in_last),
    .empty_command (in_empty),
    .state_next    (state_next),
    .bundle        (bundle)
  );

  swsp_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .load_req (in_full),
    .bundle   (bundle),
    .can_load (can_load),
    .tok_out  (tok_out)
  );

  a_cmd_clear: assert property (@(posedge clk) disable iff (rst)
    (load && (in_last || in_empty)) |=> (state == '0))
    else $error("parser state not cleared at end of command");
  a_err_idle: assert property (@(posedge clk) disable iff (rst)
    (state.first_err != ST_OK) |-> (!state.esc_pending && state.quote == QM_NONE))
    else $error("parse error with escape or quote still open");
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_full && !load) |=> (in_full && $stable(in_byte) && $stable(in_last) &&
                            $stable(in_empty)))
    else $error("waiting input word changed");

endmodule

`default_nettype wire
